// File: hdl/vlwa_pkg.sv
// ----------------------------------------------------------------------------
// vlwa_pkg
// Shared sizes, command and destination codes and the weight lookup for the
// virtual lane weighted arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package vlwa_pkg;

    localparam int NUM_LANES    = 16;
    localparam int BUFFER_SLOTS = 64;
    localparam int WEIGHT_BITS  = 8;

    localparam int NUM_QUEUES = 2 * NUM_LANES;
    localparam int SLOT_BITS  = $clog2(BUFFER_SLOTS);
    localparam int CNT_BITS   = $clog2(BUFFER_SLOTS + 1);
    localparam int QUEUE_BITS = $clog2(NUM_QUEUES);

    localparam int CMD_W     = 2;
    localparam int LANE_W    = 4;
    localparam int TAG_W     = 32;
    localparam int DEST_W    = 2;
    localparam int TDATA_W   = 40;
    localparam int REG_W     = 64;
    localparam int REG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_UPPER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [DEST_W-1:0] DEST_NET   = 2'd0;
    localparam logic [DEST_W-1:0] DEST_UPPER = 2'd1;
    localparam logic [DEST_W-1:0] DEST_DROP  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_WEIGHTS_LO = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_WEIGHTS_HI = 1'b1;

    typedef logic [QUEUE_BITS-1:0] queue_idx_t;

    // outbound queue of lane l is l, inbound queue is NUM_LANES + l
    function automatic queue_idx_t queue_index(input logic inbound,
                                               input logic [LANE_W-1:0] lane);
        int idx;
        idx = inbound ? (NUM_LANES + int'(lane)) : int'(lane);
        return QUEUE_BITS'(idx);
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] lane_weight(input logic [2*REG_W-1:0] w,
                                                           input logic [LANE_W-1:0] lane);
        logic [7:0] wbyte;
        wbyte = w[int'(lane) * 8 +: 8];
        return wbyte[WEIGHT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/virtual_lane_weighted_arbiter_core.sv
// ----------------------------------------------------------------------------
// virtual_lane_weighted_arbiter_core
// Per-lane outbound/inbound frame tag queues in a shared linked buffer, with a
// weighted round robin drain over all lanes on each tick command.
// ----------------------------------------------------------------------------
// Usage:
//   s_tuser holds the command: enqueue toward the network (frame from the
//   upper layer), enqueue toward the upper layer (frame from the network), or
//   an arbitration tick. m_* carries sent or dropped frames, destination in
//   m_tuser; m_tlast marks the final result of a command.
//   An enqueue reads the free stack and tail memory, then writes back.
//   A drop waits for the output register and then returns. A tick visits
//   each lane and round, checks each queue and sends each frame by a head
//   memory read, a frame and link memory read, then pop and write back; it
//   ends by releasing the final result. Each tick result is held back one
//   place so that tlast can be set on the final one.
//   Reset clears weights, queue lengths and the free slot stack; no pass over
//   the memories is needed. A stalled m_tready stops the tick sequencer once
//   both the hold-back and the output register are full; nothing is lost.
//   The user writes weights via cfg_* only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module virtual_lane_weighted_arbiter_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // command transactions
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [vlwa_pkg::CMD_W-1:0]    s_tuser,   // cmd[1:0]
    input  wire logic [vlwa_pkg::TDATA_W-1:0]  s_tdata,   // lane[3:0], frame_tag[35:4]
    // result transactions
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [vlwa_pkg::DEST_W-1:0]        m_tuser,   // destination[1:0]
    output logic [vlwa_pkg::TDATA_W-1:0]       m_tdata,   // out_lane[3:0], out_tag[35:4]
    output logic                               m_tlast,
    // weight register writes
    input  wire logic                          cfg_we,
    input  wire logic [vlwa_pkg::REG_IDX_W-1:0] cfg_addr,
    input  wire logic [vlwa_pkg::REG_W-1:0]    cfg_wdata
);

    localparam int SLOT_BITS  = vlwa_pkg::SLOT_BITS;
    localparam int CNT_BITS   = vlwa_pkg::CNT_BITS;
    localparam int LANE_W     = vlwa_pkg::LANE_W;
    localparam int TAG_W      = vlwa_pkg::TAG_W;
    localparam int DEST_W     = vlwa_pkg::DEST_W;
    localparam int WBITS      = vlwa_pkg::WEIGHT_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ENQ   = 3'd1;
    localparam logic [2:0] S_DROP  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_HEAD  = 3'd5;
    localparam logic [2:0] S_POP   = 3'd6;
    localparam logic [2:0] S_FLUSH = 3'd7;

    // memories
    logic [TAG_W-1:0]     frame_mem [vlwa_pkg::BUFFER_SLOTS];
    logic [SLOT_BITS-1:0] link_mem  [vlwa_pkg::BUFFER_SLOTS];
    logic [SLOT_BITS-1:0] free_mem  [vlwa_pkg::BUFFER_SLOTS];
    logic [SLOT_BITS-1:0] head_mem  [vlwa_pkg::NUM_QUEUES];
    logic [SLOT_BITS-1:0] tail_mem  [vlwa_pkg::NUM_QUEUES];

    logic [TAG_W-1:0]     frame_rdata_reg;
    logic [SLOT_BITS-1:0] link_rdata_reg;
    logic [SLOT_BITS-1:0] free_rdata_reg;
    logic [SLOT_BITS-1:0] head_rdata_reg;
    logic [SLOT_BITS-1:0] tail_rdata_reg;
    logic [SLOT_BITS-1:0] free_raddr_reg;
    logic                 free_rvalid_reg;

    // control state
    logic [2:0]                  state_reg;
    logic [vlwa_pkg::REG_W-1:0]  w_lo_reg;
    logic [vlwa_pkg::REG_W-1:0]  w_hi_reg;
    logic [CNT_BITS-1:0]         len_reg [vlwa_pkg::NUM_QUEUES];
    logic [vlwa_pkg::BUFFER_SLOTS-1:0] free_valid_reg;
    logic [CNT_BITS-1:0]         free_count_reg;
    logic [LANE_W-1:0]           lane_reg;
    logic [WBITS-1:0]            round_reg;
    logic                        side_reg;
    logic                        popped_reg;
    logic                        pend_valid_reg;
    logic                        m_valid_reg;

    // captured command and result payload
    vlwa_pkg::queue_idx_t        enq_q_reg;
    logic [TAG_W-1:0]            tag_reg;
    logic [LANE_W-1:0]           in_lane_reg;
    logic [SLOT_BITS-1:0]        slot_reg;
    logic [DEST_W-1:0]           pend_dest_reg;
    logic [LANE_W-1:0]           pend_lane_reg;
    logic [TAG_W-1:0]            pend_tag_reg;
    logic [DEST_W-1:0]           m_dest_reg;
    logic [LANE_W-1:0]           m_lane_reg;
    logic [TAG_W-1:0]            m_tag_reg;
    logic                        m_last_reg;

    // combinational
    logic [vlwa_pkg::CMD_W-1:0]  in_cmd;
    logic [LANE_W-1:0]           in_lane;
    logic [TAG_W-1:0]            in_tag;
    vlwa_pkg::queue_idx_t        in_q;
    vlwa_pkg::queue_idx_t        cur_q;
    vlwa_pkg::queue_idx_t        len_q;
    logic [CNT_BITS-1:0]         len_sel;
    logic [CNT_BITS-1:0]         free_top;
    logic [SLOT_BITS-1:0]        free_raddr;
    logic [SLOT_BITS-1:0]        free_waddr;
    logic [SLOT_BITS-1:0]        enq_slot;
    logic [SLOT_BITS-1:0]        frame_raddr;
    logic [WBITS-1:0]            cur_weight;
    logic                        in_drop;
    logic                        out_free;
    logic                        enq_go;
    logic                        pop_go;
    logic                        head_we;
    vlwa_pkg::queue_idx_t        head_waddr;
    logic [SLOT_BITS-1:0]        head_wdata;

    assign in_cmd  = s_tuser;
    assign in_lane = s_tdata[3:0];
    assign in_tag  = s_tdata[35:4];
    assign in_q    = vlwa_pkg::queue_index(in_cmd == vlwa_pkg::CMD_NET, in_lane);
    assign in_drop = (int'(in_lane) >= vlwa_pkg::NUM_LANES) || (free_count_reg == '0);

    assign cur_q      = vlwa_pkg::queue_index(side_reg, lane_reg);
    assign len_q      = (state_reg == S_ENQ) ? enq_q_reg : cur_q;
    assign len_sel    = len_reg[len_q];
    assign cur_weight = vlwa_pkg::lane_weight({w_hi_reg, w_lo_reg}, lane_reg);

    assign free_top   = free_count_reg - CNT_BITS'(1);
    assign free_raddr = free_top[SLOT_BITS-1:0];
    assign free_waddr = free_count_reg[SLOT_BITS-1:0];
    // slots never pushed back since reset hold their own index
    assign enq_slot   = free_rvalid_reg ? free_rdata_reg : free_raddr_reg;

    assign frame_raddr = (state_reg == S_HEAD) ? head_rdata_reg : slot_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign enq_go   = (state_reg == S_ENQ);
    assign pop_go   = (state_reg == S_POP) && (!pend_valid_reg || out_free);

    always_comb begin
        head_we    = 1'b0;
        head_waddr = cur_q;
        head_wdata = link_rdata_reg;
        if (enq_go && len_sel == '0) begin
            head_we    = 1'b1;
            head_waddr = enq_q_reg;
            head_wdata = enq_slot;
        end else if (pop_go) begin
            head_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (enq_go) begin
            frame_mem[enq_slot] <= tag_reg;
            tail_mem[enq_q_reg] <= enq_slot;
            if (len_sel != '0) begin
                link_mem[tail_rdata_reg] <= enq_slot;
            end
        end
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (pop_go) begin
            free_mem[free_waddr] <= slot_reg;
        end
        frame_rdata_reg <= frame_mem[frame_raddr];
        link_rdata_reg  <= link_mem[frame_raddr];
        head_rdata_reg  <= head_mem[cur_q];
        tail_rdata_reg  <= tail_mem[in_q];
        free_rdata_reg  <= free_mem[free_raddr];
        free_raddr_reg  <= free_raddr;
        free_rvalid_reg <= free_valid_reg[free_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            w_lo_reg       <= '0;
            w_hi_reg       <= '0;
            free_count_reg <= CNT_BITS'(vlwa_pkg::BUFFER_SLOTS);
            free_valid_reg <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < vlwa_pkg::NUM_QUEUES; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    vlwa_pkg::REG_WEIGHTS_LO: w_lo_reg <= cfg_wdata;
                    vlwa_pkg::REG_WEIGHTS_HI: w_hi_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        tag_reg     <= in_tag;
                        in_lane_reg <= in_lane;
                        enq_q_reg   <= in_q;
                        priority if (in_cmd == vlwa_pkg::CMD_UPPER ||
                                     in_cmd == vlwa_pkg::CMD_NET) begin
                            state_reg <= in_drop ? S_DROP : S_ENQ;
                        end else if (in_cmd == vlwa_pkg::CMD_TICK) begin
                            lane_reg  <= LANE_W'(vlwa_pkg::NUM_LANES - 1);
                            round_reg <= '0;
                            state_reg <= S_ROUND;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_ENQ: begin
                    len_reg[enq_q_reg] <= len_sel + CNT_BITS'(1);
                    free_count_reg     <= free_top;
                    state_reg          <= S_IDLE;
                end
                S_DROP: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_dest_reg  <= vlwa_pkg::DEST_DROP;
                        m_lane_reg  <= in_lane_reg;
                        m_tag_reg   <= tag_reg;
                        m_last_reg  <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_ROUND: begin
                    if (round_reg == cur_weight) begin
                        if (lane_reg == '0) begin
                            state_reg <= S_FLUSH;
                        end else begin
                            lane_reg  <= lane_reg - LANE_W'(1);
                            round_reg <= '0;
                        end
                    end else begin
                        side_reg   <= 1'b0;
                        popped_reg <= 1'b0;
                        state_reg  <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (len_sel != '0) begin
                        state_reg <= S_HEAD;
                    end else if (!side_reg) begin
                        side_reg <= 1'b1;
                    end else if (popped_reg) begin
                        round_reg <= round_reg + WBITS'(1);
                        state_reg <= S_ROUND;
                    end else if (lane_reg == '0) begin
                        // both queues empty: lane ends early
                        state_reg <= S_FLUSH;
                    end else begin
                        lane_reg  <= lane_reg - LANE_W'(1);
                        round_reg <= '0;
                        state_reg <= S_ROUND;
                    end
                end
                S_HEAD: begin
                    slot_reg  <= head_rdata_reg;
                    state_reg <= S_POP;
                end
                S_POP: begin
                    if (pop_go) begin
                        if (pend_valid_reg) begin
                            m_valid_reg <= 1'b1;
                            m_dest_reg  <= pend_dest_reg;
                            m_lane_reg  <= pend_lane_reg;
                            m_tag_reg   <= pend_tag_reg;
                            m_last_reg  <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_dest_reg  <= side_reg ? vlwa_pkg::DEST_UPPER : vlwa_pkg::DEST_NET;
                        pend_lane_reg  <= lane_reg;
                        pend_tag_reg   <= frame_rdata_reg;
                        len_reg[cur_q] <= len_sel - CNT_BITS'(1);
                        free_count_reg <= free_count_reg + CNT_BITS'(1);
                        free_valid_reg[free_waddr] <= 1'b1;
                        if (!side_reg) begin
                            popped_reg <= 1'b1;
                            side_reg   <= 1'b1;
                            state_reg  <= S_CHK;
                        end else begin
                            round_reg <= round_reg + WBITS'(1);
                            state_reg <= S_ROUND;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!pend_valid_reg) begin
                        state_reg <= S_IDLE;
                    end else if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_dest_reg     <= pend_dest_reg;
                        m_lane_reg     <= pend_lane_reg;
                        m_tag_reg      <= pend_tag_reg;
                        m_last_reg     <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_dest_reg;
    assign m_tdata  = {4'b0000, m_tag_reg, m_lane_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: dv/tb_virtual_lane_weighted_arbiter_core.sv
// ----------------------------------------------------------------------------
// tb_virtual_lane_weighted_arbiter_core
// Self-checking bench for the virtual lane weighted arbiter: drives enqueue,
// tick and unused commands, tracks every lane queue and the shared buffer in
// a scoreboard, and checks each sent or dropped frame against it.
// ----------------------------------------------------------------------------
module tb_virtual_lane_weighted_arbiter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vlwa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PCT       = 27;

    // ------------------------------------------------------------------
    // Scoreboard: per-lane tag queues plus the expected frame stream
    // ------------------------------------------------------------------
    class frame_scoreboard;
        typedef struct packed {
            logic [DEST_W-1:0] dest;
            logic [LANE_W-1:0] lane;
            logic [TAG_W-1:0]  tag;
            logic              last;
        } frame_result_t;

        logic [TAG_W-1:0]     lane_tags[NUM_QUEUES][$];
        int                   stored_frames;
        logic [2*REG_W-1:0]   lane_weights;
        frame_result_t        expected_frames[$];
        int                   mismatches;

        function new();
            stored_frames = 0;
            lane_weights  = '0;
            mismatches    = 0;
        endfunction

        function void set_weights(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
            lane_weights = {hi, lo};
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void queue_frame(input logic [DEST_W-1:0] dest, input int lane,
                                  input logic [TAG_W-1:0] tag, input logic last);
            frame_result_t r;
            r.dest = dest;
            r.lane = LANE_W'(lane);
            r.tag  = tag;
            r.last = last;
            expected_frames.push_back(r);
        endfunction

        // Accepted command: update the lane queues and predict the frames it causes.
        function void note_command(input logic [CMD_W-1:0] cmd, input logic [LANE_W-1:0] lane,
                                   input logic [TAG_W-1:0] tag);
            int q;
            int l;
            int rnd;
            int w;
            int sent;
            bit out_empty;
            logic [7:0] wbyte;
            frame_result_t tail;
            case (cmd)
                CMD_UPPER, CMD_NET: begin
                    q = (cmd == CMD_NET) ? NUM_LANES + int'(lane) : int'(lane);
                    if (stored_frames == BUFFER_SLOTS) begin
                        queue_frame(DEST_DROP, int'(lane), tag, 1'b1);
                    end else begin
                        lane_tags[q].push_back(tag);
                        stored_frames++;
                    end
                end
                CMD_TICK: begin
                    sent = 0;
                    for (l = NUM_LANES - 1; l >= 0; l--) begin
                        wbyte = lane_weights[l*8 +: 8];
                        w = int'(wbyte[WEIGHT_BITS-1:0]);
                        for (rnd = 0; rnd < w; rnd++) begin
                            out_empty = 1'b1;
                            if (lane_tags[l].size() != 0 && sent < BUFFER_SLOTS) begin
                                queue_frame(DEST_NET, l, lane_tags[l].pop_front(), 1'b0);
                                stored_frames--;
                                sent++;
                                out_empty = 1'b0;
                            end
                            if (lane_tags[NUM_LANES+l].size() != 0 && sent < BUFFER_SLOTS) begin
                                queue_frame(DEST_UPPER, l, lane_tags[NUM_LANES+l].pop_front(),
                                            1'b0);
                                stored_frames--;
                                sent++;
                            end else if (out_empty) begin
                                break;
                            end
                        end
                    end
                    if (sent > 0) begin
                        tail = expected_frames.pop_back();
                        tail.last = 1'b1;
                        expected_frames.push_back(tail);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_frame(input logic [DEST_W-1:0] user, input logic [TDATA_W-1:0] data,
                                  input logic last);
            frame_result_t got;
            frame_result_t want;
            got.dest = user;
            got.lane = data[3:0];
            got.tag  = data[35:4];
            got.last = last;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame: dest %0d lane %0d tag %h last %0d",
                             got.dest, got.lane, got.tag, got.last);
                return;
            end
            want = expected_frames.pop_front();
            if (got.dest !== want.dest || got.lane !== want.lane ||
                got.tag !== want.tag || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"frame mismatch: expected dest %0d lane %0d tag %h last %0d,",
                              " got dest %0d lane %0d tag %h last %0d"},
                             want.dest, want.lane, want.tag, want.last,
                             got.dest, got.lane, got.tag, got.last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [CMD_W-1:0]     s_tuser   = '0;
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DEST_W-1:0]    m_tuser;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr  = '0;
    logic [REG_W-1:0]     cfg_wdata = '0;

    logic                 no_idle   = 1'b0;
    int                   quiet_cycles = 0;

    frame_scoreboard board;

    virtual_lane_weighted_arbiter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // result side: random backpressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_frame(m_tuser, m_tdata, m_tlast);
    end

    // watchdog: cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("tb_virtual_lane_weighted_arbiter_core: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [LANE_W-1:0] lane,
                                input logic [TAG_W-1:0] tag);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, tag, lane};
        do @(posedge aclk); while (!s_tready);
        board.note_command(cmd, lane, tag);
    endtask

    // hold the sender until every expected frame is out, then let the sequencer finish
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_weights(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_WEIGHTS_LO;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_addr  <= REG_WEIGHTS_HI;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        board.set_weights(lo, hi);
    endtask

    task automatic send_random_mix(input int count, input int tick_pct);
        int done;
        int roll;
        done = 0;
        while (done < count) begin
            roll = $urandom_range(0, 99);
            if (roll < tick_pct) begin
                send_command(CMD_TICK, LANE_W'($urandom), $urandom);
                done++;
            end else if (roll < tick_pct + 3) begin
                send_command(CMD_UNUSED, LANE_W'($urandom), $urandom);
            end else begin
                send_command($urandom_range(0, 1) ? CMD_NET : CMD_UPPER,
                             LANE_W'($urandom_range(0, NUM_LANES - 1)), $urandom);
                done++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int ph;
        int i;
        logic [REG_W-1:0] lo;
        logic [REG_W-1:0] hi;

        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset weights are zero: ticks send nothing, unused command ignored
        send_command(CMD_UPPER, 4'd0, 32'h0000_0000);
        send_command(CMD_NET, 4'd15, 32'hFFFF_FFFF);
        send_command(CMD_TICK, 4'd0, 32'h0000_0000);
        send_command(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF);
        send_command(CMD_TICK, 4'hA, 32'h5A5A_A5A5);

        drain_and_settle();
        write_weights('1, '1);
        send_command(CMD_UPPER, 4'd15, 32'hAAAA_AAAA);
        send_command(CMD_UPPER, 4'd15, 32'h5555_5555);
        send_command(CMD_NET, 4'd15, 32'h1234_5678);
        send_command(CMD_NET, 4'd0, 32'h8765_4321);
        send_command(CMD_UPPER, 4'd7, 32'h0F0F_0F0F);
        send_command(CMD_NET, 4'd8, 32'hF0F0_F0F0);
        send_command(CMD_TICK, 4'd0, 32'h0);

        // weight 1 on low lanes, 2 on high lanes: partial drains over several ticks
        drain_and_settle();
        write_weights(64'h0101_0101_0101_0101, 64'h0202_0202_0202_0202);
        send_command(CMD_UPPER, 4'd3, 32'h0000_0031);
        send_command(CMD_UPPER, 4'd3, 32'h0000_0032);
        send_command(CMD_UPPER, 4'd3, 32'h0000_0033);
        send_command(CMD_NET, 4'd3, 32'h0000_0034);
        send_command(CMD_NET, 4'd12, 32'h0000_00C1);
        send_command(CMD_NET, 4'd12, 32'h0000_00C2);
        send_command(CMD_NET, 4'd12, 32'h0000_00C3);
        send_command(CMD_TICK, 4'd0, 32'h0);
        send_command(CMD_TICK, 4'd0, 32'h0);
        send_command(CMD_TICK, 4'd0, 32'h0);

        // fill the shared buffer, overflow it, then drain it in a single tick
        drain_and_settle();
        write_weights('0, '0);
        for (i = 0; i < 70; i++)
            send_command($urandom_range(0, 1) ? CMD_NET : CMD_UPPER,
                         LANE_W'($urandom_range(0, NUM_LANES - 1)), $urandom);
        send_command(CMD_NET, 4'd15, 32'hFFFF_FFFF);
        drain_and_settle();
        write_weights('1, '1);
        send_command(CMD_TICK, 4'd0, 32'h0);

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
                1, 2: begin
                    for (i = 0; i < 8; i++) begin
                        lo[i*8 +: 8] = 8'($urandom_range(0, 3));
                        hi[i*8 +: 8] = 8'($urandom_range(0, 3));
                    end
                end
                3: begin
                    lo = {$urandom, $urandom};
                    hi = '0;
                end
                default: begin
                    lo = '1;
                    hi = {$urandom, $urandom};
                end
            endcase
            drain_and_settle();
            write_weights(lo, hi);
            no_idle <= (ph == 2);
            send_random_mix(80, (ph == 1 || ph == 2) ? 30 : 10);
        end
        no_idle <= 1'b0;

        drain_and_settle();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_virtual_lane_weighted_arbiter_core: clean");
        else
            $display("tb_virtual_lane_weighted_arbiter_core: errors");
        $finish;
    end

endmodule
